@@ hw/rtl/lcd_rect_fill_clip_sequencer_top_defines.svh @@
// Assertion macros for the rectangle fill sequencer.
// Used by the top level only; no dependencies.
`ifndef LCD_RECT_FILL_CLIP_SEQUENCER_TOP_DEFINES_SVH
`define LCD_RECT_FILL_CLIP_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define LRFC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lrfc assertion failed");
// antecedent holds, consequent holds in the next cycle
`define LRFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lrfc assertion failed");
`else
`define LRFC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LRFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/lrfc_pkg.sv @@
// Shared types and constants for the rectangle fill sequencer.
// No dependencies.
`default_nettype none

package lrfc_pkg;

    localparam int DIM_W = 11;
    localparam int RUN_W = 21;
    localparam int COORD_W = 16;

    // register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

    // controller command codes
    localparam logic [15:0] CMD_CASET = 16'h002A;
    localparam logic [15:0] CMD_PASET = 16'h002B;
    localparam logic [15:0] CMD_RAMWR = 16'h002C;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_RUN  = 2'd2
    } word_kind_t;

    typedef enum logic [2:0] {
        STEP_CASET,
        STEP_X0,
        STEP_X1,
        STEP_PASET,
        STEP_Y0,
        STEP_Y1,
        STEP_RAMWR,
        STEP_RUN
    } seq_step_t;

    // one clipped fill job
    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] y_end;
        logic [15:0]        color;
        logic [RUN_W-1:0]   run;
    } job_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/lrfc_front.sv @@
// Front end: accepts fill requests, normalises, rejects and clips them,
// and computes the pixel count. Depends on lrfc_pkg.
`default_nettype none

module lrfc_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [lrfc_pkg::DIM_W-1:0]   screen_w,
    input  wire logic [lrfc_pkg::DIM_W-1:0]   screen_h,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [15:0]           corner_x,
    input  wire logic signed [15:0]           corner_y,
    input  wire logic signed [15:0]           span_w,
    input  wire logic signed [15:0]           span_h,
    input  wire logic [15:0]                  fill_color,
    input  wire lrfc_pkg::q_stat_t            q_stat,
    output logic                              push,
    output lrfc_pkg::job_t                    push_job
);

    logic [15:0] sw16, sh16;
    logic        adv;

    // stage a: normalised corner and far edge
    logic [15:0] x_adj, y_adj, x_far, y_far;
    logic        rej;
    logic        a_valid_reg, a_valid_next;
    logic [15:0] a_x_reg, a_x2_reg, a_y_reg, a_y2_reg, a_color_reg;

    // stage b: clipped edges and size
    logic [15:0] xs, xe, ys, ye, wfull, hfull;
    logic        b_valid_reg;
    logic [15:0] b_xs_reg, b_xe_reg, b_ys_reg, b_ye_reg, b_color_reg;
    logic [lrfc_pkg::DIM_W-1:0] b_w_reg, b_h_reg;

    // stage c: pixel count
    logic                         c_valid_reg;
    logic [2*lrfc_pkg::DIM_W-1:0] prod;
    lrfc_pkg::job_t               c_job_reg;

    assign sw16 = {5'b0, screen_w};
    assign sh16 = {5'b0, screen_h};

    // whole pipeline holds while the last stage cannot enter the queue
    assign adv      = !(c_valid_reg && q_stat.full);
    assign in_ready = adv;

    // a negative span moves the corner; the far edge is then the old corner
    always_comb begin
        x_adj = span_w[15] ? 16'(corner_x + span_w + 16'sd1) : corner_x;
        x_far = span_w[15] ? corner_x : 16'(corner_x + span_w - 16'sd1);
        y_adj = span_h[15] ? 16'(corner_y + span_h + 16'sd1) : corner_y;
        y_far = span_h[15] ? corner_y : 16'(corner_y + span_h - 16'sd1);
        rej = (span_w == 16'sd0) || (span_h == 16'sd0)
            || !($signed(x_adj) < $signed(sw16))
            || !($signed(y_adj) < $signed(sh16))
            || x_far[15] || y_far[15];
        a_valid_next = in_valid && !rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_x_reg     <= x_adj;
            a_x2_reg    <= x_far;
            a_y_reg     <= y_adj;
            a_y2_reg    <= y_far;
            a_color_reg <= fill_color;
        end
    end

    // clip to the screen; start at zero, end at the last visible pixel
    always_comb begin
        xs    = a_x_reg[15] ? 16'd0 : a_x_reg;
        ys    = a_y_reg[15] ? 16'd0 : a_y_reg;
        xe    = ($signed(a_x2_reg) >= $signed(sw16)) ? 16'(sw16 - 16'd1) : a_x2_reg;
        ye    = ($signed(a_y2_reg) >= $signed(sh16)) ? 16'(sh16 - 16'd1) : a_y2_reg;
        wfull = 16'(xe - xs + 16'd1);
        hfull = 16'(ye - ys + 16'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_xs_reg    <= xs;
            b_xe_reg    <= xe;
            b_ys_reg    <= ys;
            b_ye_reg    <= ye;
            b_w_reg     <= wfull[lrfc_pkg::DIM_W-1:0];
            b_h_reg     <= hfull[lrfc_pkg::DIM_W-1:0];
            b_color_reg <= a_color_reg;
        end
    end

    // width times height
    assign prod = b_w_reg * b_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_job_reg.x_start <= b_xs_reg;
            c_job_reg.x_end   <= b_xe_reg;
            c_job_reg.y_start <= b_ys_reg;
            c_job_reg.y_end   <= b_ye_reg;
            c_job_reg.color   <= b_color_reg;
            c_job_reg.run     <= prod[lrfc_pkg::RUN_W-1:0];
        end
    end

    assign push     = c_valid_reg && !q_stat.full;
    assign push_job = c_job_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lrfc_queue.sv @@
// Four-entry job queue between the front and back ends.
// Depends on lrfc_pkg.
`default_nettype none

module lrfc_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire lrfc_pkg::job_t push_job,
    input  wire logic           pop,
    output lrfc_pkg::job_t      head_job,
    output lrfc_pkg::q_stat_t   q_stat
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    lrfc_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign q_stat.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ hw/rtl/lrfc_back.sv @@
// Back end: walks each queued job through its eight output words
// into a registered output stage. Depends on lrfc_pkg.
`default_nettype none

module lrfc_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire lrfc_pkg::job_t             head_job,
    input  wire lrfc_pkg::q_stat_t          q_stat,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      out_kind,
    output logic [15:0]                     out_value,
    output logic [lrfc_pkg::RUN_W-1:0]      out_run,
    output logic                            out_last
);

    lrfc_pkg::seq_step_t           step_reg, step_next;
    logic                          valid_reg, valid_next;
    lrfc_pkg::word_kind_t          kind_reg, kind_next;
    logic [15:0]                   value_reg, value_next;
    logic [lrfc_pkg::RUN_W-1:0]    run_reg, run_next;
    logic                          last_reg, last_next;
    logic                          out_free, emit;

    assign out_free = !valid_reg || out_ready;
    assign emit     = out_free && !q_stat.empty;

    // word sequencer
    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        run_next   = run_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (out_free) begin
            valid_next = emit;
        end
        if (emit) begin
            run_next  = lrfc_pkg::RUN_W'(1);
            last_next = 1'b0;
            case (step_reg)
                lrfc_pkg::STEP_CASET: begin
                    kind_next  = lrfc_pkg::KIND_CMD;
                    value_next = lrfc_pkg::CMD_CASET;
                    step_next  = lrfc_pkg::STEP_X0;
                end
                lrfc_pkg::STEP_X0: begin
                    kind_next  = lrfc_pkg::KIND_DATA;
                    value_next = head_job.x_start;
                    step_next  = lrfc_pkg::STEP_X1;
                end
                lrfc_pkg::STEP_X1: begin
                    kind_next  = lrfc_pkg::KIND_DATA;
                    value_next = head_job.x_end;
                    step_next  = lrfc_pkg::STEP_PASET;
                end
                lrfc_pkg::STEP_PASET: begin
                    kind_next  = lrfc_pkg::KIND_CMD;
                    value_next = lrfc_pkg::CMD_PASET;
                    step_next  = lrfc_pkg::STEP_Y0;
                end
                lrfc_pkg::STEP_Y0: begin
                    kind_next  = lrfc_pkg::KIND_DATA;
                    value_next = head_job.y_start;
                    step_next  = lrfc_pkg::STEP_Y1;
                end
                lrfc_pkg::STEP_Y1: begin
                    kind_next  = lrfc_pkg::KIND_DATA;
                    value_next = head_job.y_end;
                    step_next  = lrfc_pkg::STEP_RAMWR;
                end
                lrfc_pkg::STEP_RAMWR: begin
                    kind_next  = lrfc_pkg::KIND_CMD;
                    value_next = lrfc_pkg::CMD_RAMWR;
                    step_next  = lrfc_pkg::STEP_RUN;
                end
                lrfc_pkg::STEP_RUN: begin
                    kind_next  = lrfc_pkg::KIND_RUN;
                    value_next = head_job.color;
                    run_next   = head_job.run;
                    last_next  = 1'b1;
                    step_next  = lrfc_pkg::STEP_CASET;
                    pop        = 1'b1;
                end
                default: begin
                    step_next = lrfc_pkg::STEP_CASET;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= lrfc_pkg::STEP_CASET;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        run_reg   <= run_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_run   = run_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lcd_rect_fill_clip_sequencer_top.sv @@
// Top level of the clipped rectangle fill sequencer: screen size registers,
// front end, job queue and back end. Depends on lrfc_pkg and the defines header.
//
// Usage:
//   s_ channel (valid/ready) takes one fill request: signed corner, signed
//   span and an RGB565 colour. m_ channel (valid/ready) gives the words for
//   the display: column command, start, end, row command, start, end,
//   memory-write command, then one colour run with m_last_word set.
//   Requests of zero size or wholly off screen give no words at all.
//   cfg_wr_en/cfg_index/cfg_wdata write screen width (0) and height (1);
//   zero is stored as one, values above MAX_DIM as MAX_DIM; other indexes
//   are ignored. Write only while no transaction is in flight.
//   A request's first word shows on m_ once it has passed front stages a,
//   b and c, the job queue and the back end's output word register. The back
//   end's word sequencer gives one word per cycle on m_ while m_ready is
//   high and a job is queued. A three-stage front end and a four-entry queue
//   let s_ keep accepting while m_ is stalled, until the queue fills.
//   Reset (aresetn low, synchronous) empties the pipeline and queue and sets
//   the screen to 240 by 320.
`default_nettype none
`include "lcd_rect_fill_clip_sequencer_top_defines.svh"

module lcd_rect_fill_clip_sequencer_top #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [lrfc_pkg::DIM_W-1:0]   cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [15:0]           s_corner_x,
    input  wire logic signed [15:0]           s_corner_y,
    input  wire logic signed [15:0]           s_span_w,
    input  wire logic signed [15:0]           s_span_h,
    input  wire logic [15:0]                  s_fill_color,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_word_kind,
    output logic [15:0]                       m_word_value,
    output logic [lrfc_pkg::RUN_W-1:0]        m_run_length,
    output logic                              m_last_word
);

    localparam logic [lrfc_pkg::DIM_W+1:0] MaxDimC = (lrfc_pkg::DIM_W+2)'(MAX_DIM);

    logic [lrfc_pkg::DIM_W-1:0] screen_w_reg, screen_h_reg, dim_clamped;
    logic                       push, pop;
    lrfc_pkg::job_t             push_job, head_job;
    lrfc_pkg::q_stat_t          q_stat;

    // clamp a written dimension to 1..MAX_DIM
    always_comb begin
        if (cfg_wdata == '0) begin
            dim_clamped = lrfc_pkg::DIM_W'(1);
        end else if ({2'b00, cfg_wdata} > MaxDimC) begin
            dim_clamped = MaxDimC[lrfc_pkg::DIM_W-1:0];
        end else begin
            dim_clamped = cfg_wdata;
        end
    end

    // screen size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg <= lrfc_pkg::DIM_W'(240);
            screen_h_reg <= lrfc_pkg::DIM_W'(320);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lrfc_pkg::REG_SCREEN_WIDTH:  screen_w_reg <= dim_clamped;
                lrfc_pkg::REG_SCREEN_HEIGHT: screen_h_reg <= dim_clamped;
                default: ;
            endcase
        end
    end

    lrfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .screen_w   (screen_w_reg),
        .screen_h   (screen_h_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .corner_x   (s_corner_x),
        .corner_y   (s_corner_y),
        .span_w     (s_span_w),
        .span_h     (s_span_h),
        .fill_color (s_fill_color),
        .q_stat     (q_stat),
        .push       (push),
        .push_job   (push_job)
    );

    lrfc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    lrfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_kind  (m_word_kind),
        .out_value (m_word_value),
        .out_run   (m_run_length),
        .out_last  (m_last_word)
    );

    // checks
    `LRFC_ASSERT_SAME(a_last_is_run, aclk, aresetn, m_valid && m_last_word, m_word_kind == lrfc_pkg::KIND_RUN)
    `LRFC_ASSERT_SAME(a_run_nonzero, aclk, aresetn, m_valid && m_word_kind == lrfc_pkg::KIND_RUN, m_run_length != '0 && m_last_word)
    `LRFC_ASSERT_NEXT(a_seq_restart, aclk, aresetn, m_valid && m_ready && m_last_word, !m_valid || (m_word_kind == lrfc_pkg::KIND_CMD && m_word_value == lrfc_pkg::CMD_CASET))
    `LRFC_ASSERT_SAME(a_no_push_full, aclk, aresetn, push, !q_stat.full)

endmodule

`default_nettype wire
